[hw/rtl/dffir_pkg.sv]
// Package for the direct-form FIR filter: word types, field widths and codes.
// Used by dffir_mac and direct_form_fir_filter_top. No dependencies.
package dffir_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = SAMPLE_BITS - 1;
  localparam int TAP_INDEX_BITS = 8;
  localparam int TAP_COUNT_BITS = 9;

  // Codes of the kind field.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;
  } out_word_t;

  // Travels with each tap read through the multiply-accumulate stages.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_OUT
  } state_t;

endpackage

[hw/rtl/dffir_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module dffir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dffir_mac.sv]
// Multiply-accumulate datapath: registered product, wide accumulator, and
// round-to-nearest with saturation of the sum. Depends on dffir_pkg.
module dffir_mac #(
  parameter int ACC_W = 41
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  dffir_pkg::mac_ctrl_t                       ctl,
  input  logic signed [dffir_pkg::SAMPLE_BITS-1:0]   coef,
  input  logic signed [dffir_pkg::SAMPLE_BITS-1:0]   smp,
  output logic                                       done,
  output dffir_pkg::out_word_t                       res
);

  localparam int SB = dffir_pkg::SAMPLE_BITS;
  localparam int FB = dffir_pkg::FRAC_BITS;
  localparam logic signed [ACC_W:0] HALF   = (ACC_W+1)'(1 << (FB - 1));
  localparam logic signed [ACC_W:0] LIM_HI = (ACC_W+1)'((1 << FB) - 1);
  localparam logic signed [ACC_W:0] LIM_LO = (ACC_W+1)'(-(1 << FB));

  dffir_pkg::mac_ctrl_t       p_ctl;
  logic signed [2*SB-1:0]     prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W:0]      rnd;
  logic signed [ACC_W:0]      quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
      done  <= 1'b0;
    end else begin
      p_ctl <= ctl;
      done  <= p_ctl.vld & p_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * smp;
    if (p_ctl.vld) begin
      if (p_ctl.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // Adding one half and shifting right rounds to nearest, ties upward.
  always_comb begin
    rnd = (ACC_W+1)'(acc) + HALF;
    quo = rnd >>> FB;
    if (quo > LIM_HI) begin
      res.sample_out = LIM_HI[SB-1:0];
      res.saturated  = 1'b1;
    end else if (quo < LIM_LO) begin
      res.sample_out = LIM_LO[SB-1:0];
      res.saturated  = 1'b1;
    end else begin
      res.sample_out = quo[SB-1:0];
      res.saturated  = 1'b0;
    end
  end

endmodule

[hw/rtl/direct_form_fir_filter_top.sv]
// Top level of the direct-form FIR filter: sequencer, delay-line and
// coefficient RAMs, and output register. Depends on dffir_pkg, dffir_ram, dffir_mac.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    dffir_pkg::in_word_t
//   out      output     out_valid/out_ready  dffir_pkg::out_word_t
//   cfg      input      cfg_wen              tap_count (9 bits)
//
// A coefficient word is written to its RAM as it is taken. A sample word holds off the
// next word for a walk over taps, where taps is tap_count with zero read as one and counts above
// MAX_TAPS clipped: the delay-line write, one RAM read per tap,
// then draining the multiply and accumulate stages and loading the output.
// After reset a clearing pass zeroes every address of both RAMs with in_ready low;
// configuration writes are taken meanwhile. A result that waits on out_ready
// holds only the final load; new words are accepted while it waits.
module direct_form_fir_filter_top #(
  parameter int MAX_TAPS = 256
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  dffir_pkg::in_word_t                          in_data,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output dffir_pkg::out_word_t                         out_data,
  input  logic                                         cfg_wen,
  input  logic [dffir_pkg::TAP_COUNT_BITS-1:0]         cfg_wdata
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int SB    = dffir_pkg::SAMPLE_BITS;
  localparam int ACC_W = 2 * SB + AW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  dffir_pkg::state_t    state, state_next;
  dffir_pkg::mac_ctrl_t rd_ctl;
  dffir_pkg::out_word_t mac_res;

  logic [dffir_pkg::TAP_COUNT_BITS-1:0] tap_count;
  logic [AW-1:0] insert_pos, ins_next, taps_last, last_idx;
  logic [AW-1:0] j, pos, clr_addr, tap_addr;
  logic [31:0]   tc_m1, idx32;
  logic          accept, smp_acc, coef_acc, clearing, out_load, acc_done;

  logic          dl_we, cf_we;
  logic [AW-1:0] dl_waddr, cf_waddr;
  logic [SB-1:0] dl_wdata, cf_wdata, dl_rdata, cf_rdata;

  // Tap count zero acts as one tap; counts above the memory depth are clipped.
  assign tc_m1 = 32'(tap_count) - 32'd1;
  always_comb begin
    if (tap_count == '0) begin
      taps_last = '0;
    end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
      taps_last = LAST_ADDR;
    end else begin
      taps_last = tc_m1[AW-1:0];
    end
  end

  // A position at or past the last tap wraps, which also covers a shrunk count.
  assign ins_next = (insert_pos >= taps_last) ? '0 : insert_pos + 1'b1;

  assign idx32    = 32'(in_data.tap_index);
  assign tap_addr = idx32[AW-1:0];

  assign in_ready = (state == dffir_pkg::S_IDLE);
  assign accept   = in_valid & in_ready;
  assign smp_acc  = accept & (in_data.kind == dffir_pkg::KIND_SAMPLE);
  assign coef_acc = accept & (in_data.kind == dffir_pkg::KIND_COEF)
                  & (idx32 < 32'(MAX_TAPS));
  assign clearing = (state == dffir_pkg::S_CLEAR);
  assign out_load = (state == dffir_pkg::S_OUT) & (~out_valid | out_ready);

  always_comb begin
    state_next = state;
    case (state)
      dffir_pkg::S_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = dffir_pkg::S_IDLE;
      end
      dffir_pkg::S_IDLE: begin
        if (smp_acc) state_next = dffir_pkg::S_RUN;
      end
      dffir_pkg::S_RUN: begin
        if (j == last_idx) state_next = dffir_pkg::S_WAIT;
      end
      dffir_pkg::S_WAIT: begin
        if (acc_done) state_next = dffir_pkg::S_OUT;
      end
      dffir_pkg::S_OUT: begin
        if (out_load) state_next = dffir_pkg::S_IDLE;
      end
      default: state_next = dffir_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dffir_pkg::S_CLEAR;
      clr_addr   <= '0;
      insert_pos <= '0;
      tap_count  <= dffir_pkg::TAP_COUNT_BITS'(1);
      rd_ctl     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        tap_count <= cfg_wdata;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (smp_acc) begin
        insert_pos <= ins_next;
      end
      rd_ctl.vld   <= (state == dffir_pkg::S_RUN);
      rd_ctl.first <= (j == '0);
      rd_ctl.last  <= (j == last_idx);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk counters: j indexes the coefficients, pos steps back through the line.
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      last_idx <= taps_last;
      j        <= '0;
      pos      <= ins_next;
    end else if (state == dffir_pkg::S_RUN) begin
      j   <= j + 1'b1;
      pos <= (pos == '0) ? last_idx : pos - 1'b1;
    end
    if (out_load) begin
      out_data <= mac_res;
    end
  end

  assign dl_we    = clearing | smp_acc;
  assign dl_waddr = clearing ? clr_addr : ins_next;
  assign dl_wdata = clearing ? '0 : in_data.sample_in;
  assign cf_we    = clearing | coef_acc;
  assign cf_waddr = clearing ? clr_addr : tap_addr;
  assign cf_wdata = clearing ? '0 : in_data.coef_value;

  dffir_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (pos),
    .rdata (dl_rdata)
  );

  dffir_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (j),
    .rdata (cf_rdata)
  );

  dffir_mac #(.ACC_W(ACC_W)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .coef ($signed(cf_rdata)),
    .smp  ($signed(dl_rdata)),
    .done (acc_done),
    .res  (mac_res)
  );

`ifndef SYNTHESIS
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == dffir_pkg::S_RUN) |-> (j <= last_idx && pos <= last_idx))
    else $error("tap walk left the active delay line");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> (state == dffir_pkg::S_WAIT))
    else $error("accumulator finished outside the wait state");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == dffir_pkg::S_OUT))
    else $error("output word raised without a result load");

  a_no_walk_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!rd_ctl.vld && !acc_done))
    else $error("input accepted while a tap walk was still in flight");
`endif

endmodule
